FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, muted while reset is asserted
`define IMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked property, checked during reset too
`define IMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// Shared constants, codes and control types of the indexed multi-stack.
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int NUM_STACKS_DEF  = 16;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int IDX_W      = 4;
    localparam int VAL_W      = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TOP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_ALT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RSVD  = 2'd3;

    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic load_out;
    } ims_cmd_t;

    typedef struct packed {
        logic clr_last;
    } ims_stat_t;

endpackage

FILE: design/ims_datapath.sv
// ----------------------------------------------------------------------------
// ims_datapath
// Count memory, element memory, request holding and result register.
// ----------------------------------------------------------------------------
module ims_datapath #(
    parameter int NUM_STACKS  = ims_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = ims_pkg::STACK_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ims_pkg::ims_cmd_t                cmd,
    output ims_pkg::ims_stat_t               stat,
    input  logic [ims_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [ims_pkg::IN_USER_W-1:0]    in_user,
    output logic [ims_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [ims_pkg::OUT_USER_W-1:0]   out_user
);

    localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [CNT_W-1:0]             cnt_mem [NUM_STACKS];
    logic [ims_pkg::VAL_W-1:0]    store_mem [WORDS];

    logic [SIDX_W-1:0]            clr_ptr_reg;
    logic [SIDX_W-1:0]            clr_ptr_next;

    logic [ims_pkg::REQ_W-1:0]    req_reg;
    logic [SIDX_W-1:0]            idx_reg;
    logic                         in_range_reg;
    logic [ims_pkg::VAL_W-1:0]    val_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [ims_pkg::VAL_W-1:0]    rd_data_reg;
    logic [ims_pkg::STATUS_W-1:0] status_reg;
    logic                         topv_reg;

    logic [ims_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_topv_reg;
    logic [ims_pkg::VAL_W-1:0]    out_value_reg;

    logic [ims_pkg::IDX_W-1:0]    in_index;
    logic                         is_push;
    logic                         is_top;
    logic                         full;
    logic                         empty;
    logic                         push_ok;
    logic                         pop_ok;
    logic                         top_ok;
    logic [ims_pkg::STATUS_W-1:0] status_calc;
    logic [ADDR_W-1:0]            base_addr;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            rd_addr;

    assign in_index = in_data[ims_pkg::IDX_W-1:0];

    assign is_push = (req_reg == ims_pkg::REQ_PUSH);
    assign is_top  = (req_reg == ims_pkg::REQ_TOP);
    assign full    = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = in_range_reg && is_push && !full;
    assign top_ok  = in_range_reg && is_top && !empty;
    assign pop_ok  = in_range_reg && !is_push && !is_top && !empty;

    always_comb
    begin
        if (is_push)
        begin
            status_calc = push_ok ? ims_pkg::ST_OK : ims_pkg::ST_FULL;
        end
        else
        begin
            status_calc = (top_ok || pop_ok) ? ims_pkg::ST_OK : ims_pkg::ST_EMPTY;
        end
    end

    assign base_addr = ADDR_W'(idx_reg) * ADDR_W'(STACK_DEPTH);
    assign wr_addr   = base_addr + ADDR_W'(cnt_reg);
    assign rd_addr   = base_addr + ADDR_W'(cnt_reg - CNT_W'(1));

    assign clr_ptr_next = cmd.clear ? clr_ptr_reg + SIDX_W'(1) : clr_ptr_reg;
    assign stat.clr_last = (clr_ptr_reg == SIDX_W'(NUM_STACKS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else
        begin
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            cnt_mem[clr_ptr_reg] <= '0;
        end
        else if (cmd.look && push_ok)
        begin
            cnt_mem[idx_reg] <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.look && pop_ok)
        begin
            cnt_mem[idx_reg] <= cnt_reg - CNT_W'(1);
        end
        if (cmd.accept)
        begin
            cnt_reg <= cnt_mem[SIDX_W'(in_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look && push_ok)
        begin
            store_mem[wr_addr] <= val_reg;
        end
        if (cmd.look && top_ok)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg      <= in_user;
            idx_reg      <= SIDX_W'(in_index);
            in_range_reg <= (32'(in_index) < 32'(NUM_STACKS));
            val_reg      <= in_data[ims_pkg::IDX_W +: ims_pkg::VAL_W];
        end
        if (cmd.look)
        begin
            status_reg <= status_calc;
            topv_reg   <= top_ok;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_topv_reg   <= topv_reg;
            out_value_reg  <= topv_reg ? rd_data_reg : '0;
        end
    end

    // tuser: status[1:0], top_valid[2]; tdata: top_value[31:0]
    assign out_user = {out_topv_reg, out_status_reg};
    assign out_data = out_value_reg;

endmodule

FILE: design/ims_ctrl.sv
// ----------------------------------------------------------------------------
// ims_ctrl
// Sequencer: count clearing pass, request accept, lookup and result handoff.
// ----------------------------------------------------------------------------
module ims_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ims_pkg::ims_cmd_t  cmd,
    input  ims_pkg::ims_stat_t stat
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/indexed_multi_stack_core.sv
// ----------------------------------------------------------------------------
// indexed_multi_stack_core
// Bank of independent LIFO stacks with push, read top and pop requests.
//
//   channel   dir   tdata                                 tuser
//   s_axis    in    stack_index[3:0] push_value[35:4]     req_type[1:0]
//   m_axis    out   top_value[31:0]                       status[1:0] top_valid[2]
//
// Each request passes through accept, count memory lookup and result load
// before the next is taken; the registered reads of the count and element memories set these steps.
// After reset the count memory is cleared, one stack per cycle, while
// s_axis_tready stays low.
// A stalled m_axis holds the result; the next request is taken meanwhile
// and waits for the output register before it is handed on.
// ----------------------------------------------------------------------------
module indexed_multi_stack_core #(
    parameter int NUM_STACKS  = ims_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = ims_pkg::STACK_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ims_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // stack_index, push_value, pad
    input  logic [ims_pkg::IN_USER_W-1:0]     s_axis_tuser,  // req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ims_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // top_value
    output logic [ims_pkg::OUT_USER_W-1:0]    m_axis_tuser   // status, top_valid
);

    ims_pkg::ims_cmd_t  cmd;
    ims_pkg::ims_stat_t stat;

    ims_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ims_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .out_data (m_axis_tdata),
        .out_user (m_axis_tuser)
    );

endmodule

FILE: design/ims_checker.sv
// ----------------------------------------------------------------------------
// ims_checker
// Port-level checks on the result stream of the indexed multi-stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ims_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ims_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ims_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    logic [ims_pkg::STATUS_W-1:0]                    res_status;
    logic                                            res_top;
    logic                                            res_plain;
    logic                                            res_stall;
    logic [ims_pkg::OUT_USER_W+ims_pkg::OUT_DATA_W-1:0] res_bus;

    assign res_status = m_axis_tuser[1:0];
    assign res_top    = m_axis_tvalid && m_axis_tuser[2];
    assign res_plain  = m_axis_tvalid && !m_axis_tuser[2];
    assign res_stall  = m_axis_tvalid && !m_axis_tready;
    assign res_bus    = {m_axis_tuser, m_axis_tdata};

    `IMS_ASSERT_ALWAYS(a_rst_no_valid, clk, !rst_n |-> !m_axis_tvalid, "result valid in reset")

    `IMS_ASSERT(a_hold, clk, rst_n, res_stall |=> m_axis_tvalid && $stable(res_bus), "held moved")

    `IMS_ASSERT(a_top_ok, clk, rst_n, res_top |-> res_status == ims_pkg::ST_OK, "top without ok")

    `IMS_ASSERT(a_status, clk, rst_n, m_axis_tvalid |-> res_status != ims_pkg::ST_RSVD, "bad status")

    `IMS_ASSERT(a_zero_value, clk, rst_n, res_plain |-> m_axis_tdata == '0, "value without top")

endmodule

bind indexed_multi_stack_core ims_checker u_ims_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/indexed_multi_stack_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_multi_stack_core_tb
// Self-checking bench for the indexed multi-stack core. A scoreboard class
// keeps its own copy of every stack and its element count, predicts the
// status and top value of each request, and checks the results in order.
// A short directed pass hits the value and index extremes, every request
// code and the empty cases. It is followed by random fill past full, drain
// and mixed bursts, with random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module indexed_multi_stack_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STACKS  = ims_pkg::NUM_STACKS_DEF;
    localparam int STACK_DEPTH = ims_pkg::STACK_DEPTH_DEF;
    localparam int ITEM_TARGET = 700;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [ims_pkg::STATUS_W-1:0] status;
        logic                         top_valid;
        logic [ims_pkg::VAL_W-1:0]    top_value;
    } stack_result_t;

    class stack_scoreboard_t;
        logic [ims_pkg::VAL_W-1:0] words [NUM_STACKS][STACK_DEPTH];
        int unsigned               depth_used [NUM_STACKS];
        stack_result_t             pending [$];
        int unsigned               errors;
        int unsigned               n_push, n_top, n_pop, n_full, n_empty, n_checked;

        function new();
            foreach (depth_used[i])
                depth_used[i] = 0;
            errors = 0;
            n_push = 0; n_top = 0; n_pop = 0;
            n_full = 0; n_empty = 0; n_checked = 0;
        endfunction

        function void note_request(logic [ims_pkg::REQ_W-1:0] op,
                                   logic [ims_pkg::IDX_W-1:0] idx,
                                   logic [ims_pkg::VAL_W-1:0] val);
            stack_result_t res;
            int unsigned   cnt;
            res = '0;
            if (op == ims_pkg::REQ_PUSH)
                n_push++;
            else if (op == ims_pkg::REQ_TOP)
                n_top++;
            else
                n_pop++;
            if (int'(idx) >= NUM_STACKS)
            begin
                res.status = (op == ims_pkg::REQ_PUSH) ? ims_pkg::ST_FULL : ims_pkg::ST_EMPTY;
            end
            else
            begin
                cnt = depth_used[idx];
                if (op == ims_pkg::REQ_PUSH)
                begin
                    if (cnt >= STACK_DEPTH)
                    begin
                        res.status = ims_pkg::ST_FULL;
                    end
                    else
                    begin
                        words[idx][cnt] = val;
                        depth_used[idx] = cnt + 1;
                        res.status      = ims_pkg::ST_OK;
                    end
                end
                else if (op == ims_pkg::REQ_TOP)
                begin
                    if (cnt == 0)
                    begin
                        res.status = ims_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res.status    = ims_pkg::ST_OK;
                        res.top_valid = 1'b1;
                        res.top_value = words[idx][cnt-1];
                    end
                end
                else
                begin
                    if (cnt == 0)
                    begin
                        res.status = ims_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        depth_used[idx] = cnt - 1;
                        res.status      = ims_pkg::ST_OK;
                    end
                end
            end
            if (res.status == ims_pkg::ST_FULL)
                n_full++;
            if (res.status == ims_pkg::ST_EMPTY)
                n_empty++;
            pending.insert(pending.size(), res);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns  MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [ims_pkg::OUT_USER_W-1:0] user,
                          logic [ims_pkg::OUT_DATA_W-1:0] data);
            stack_result_t want;
            n_checked++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result user=%h data=%h", user, data));
            end
            else
            begin
                want = pending[0];
                pending.delete(0);
                if (user[1:0] !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              n_checked, user[1:0], want.status));
                if (user[2] !== want.top_valid)
                    report_mismatch($sformatf("result %0d top_valid %0b, want %0b",
                                              n_checked, user[2], want.top_valid));
                if (data !== want.top_value)
                    report_mismatch($sformatf("result %0d top_value %h, want %h",
                                              n_checked, data, want.top_value));
            end
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [ims_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // stack_index, push_value, pad
    logic [ims_pkg::IN_USER_W-1:0]  s_axis_tuser;   // req_type
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [ims_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // top_value
    logic [ims_pkg::OUT_USER_W-1:0] m_axis_tuser;   // status, top_valid

    stack_scoreboard_t sb;
    bit                steady;
    int unsigned       sent;
    int unsigned       idle_cycles;

    indexed_multi_stack_core #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_request(input logic [ims_pkg::REQ_W-1:0] op,
                                input logic [ims_pkg::IDX_W-1:0] idx,
                                input logic [ims_pkg::VAL_W-1:0] val);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(ims_pkg::IN_DATA_W - ims_pkg::VAL_W - ims_pkg::IDX_W){1'b0}},
                          val, idx};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, idx, val);
        sent++;
    endtask

    function automatic logic [ims_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ims_pkg::REQ_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return ims_pkg::REQ_PUSH;
        else if (r < 70)
            return ims_pkg::REQ_TOP;
        else if (r < 95)
            return ims_pkg::REQ_POP;
        else
            return ims_pkg::REQ_POP_ALT;
    endfunction

    // receive side: random stall before each result, check on transfer
    initial
    begin
        int unsigned stall;
        m_axis_tready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ims_pkg::IDX_W-1:0] idx;
        int unsigned               kind;
        int unsigned               n;
        sb            = new();
        steady        = 1'b0;
        sent          = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ims_pkg::REQ_PUSH;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: value and index extremes, every request code, empty cases
        send_request(ims_pkg::REQ_TOP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_POP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_POP_ALT, 4'd15, 32'hFFFF_FFFF);
        send_request(ims_pkg::REQ_PUSH,    4'd0,  32'h8000_0000);
        send_request(ims_pkg::REQ_PUSH,    4'd0,  32'h7FFF_FFFF);
        send_request(ims_pkg::REQ_TOP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_POP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_TOP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_POP_ALT, 4'd0,  32'h0);
        send_request(ims_pkg::REQ_TOP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_POP,     4'd0,  32'h0);
        send_request(ims_pkg::REQ_PUSH,    4'd15, 32'hFFFF_FFFF);
        send_request(ims_pkg::REQ_PUSH,    4'd5,  32'h0000_0000);
        send_request(ims_pkg::REQ_PUSH,    4'd10, 32'h5555_5555);
        send_request(ims_pkg::REQ_PUSH,    4'd10, 32'hAAAA_AAAA);
        send_request(ims_pkg::REQ_TOP,     4'd15, 32'h0);
        send_request(ims_pkg::REQ_TOP,     4'd5,  32'h0);
        send_request(ims_pkg::REQ_TOP,     4'd10, 32'h0);
        send_request(ims_pkg::REQ_POP_ALT, 4'd10, 32'h0);
        send_request(ims_pkg::REQ_TOP,     4'd10, 32'h0);

        // random bursts: fill to full, drain to empty, mixed traffic
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 39) == 0)
                steady = ~steady;
            idx  = ims_pkg::IDX_W'($urandom_range(0, NUM_STACKS - 1));
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                while (sb.depth_used[idx] < STACK_DEPTH)
                    send_request(ims_pkg::REQ_PUSH, idx, pick_value());
                n = $urandom_range(1, 3);
                repeat (n) send_request(ims_pkg::REQ_PUSH, idx, pick_value());
                send_request(ims_pkg::REQ_TOP, idx, $urandom());
            end
            else if (kind == 1)
            begin
                while (sb.depth_used[idx] > 0)
                    send_request(($urandom_range(0, 3) == 0) ? ims_pkg::REQ_TOP
                                                             : ims_pkg::REQ_POP,
                                 idx, $urandom());
                n = $urandom_range(1, 2);
                repeat (n) send_request(pick_op() == ims_pkg::REQ_TOP ? ims_pkg::REQ_TOP
                                                                      : ims_pkg::REQ_POP_ALT,
                                        idx, $urandom());
            end
            else
            begin
                n = $urandom_range(4, 12);
                repeat (n) send_request(pick_op(), idx, pick_value());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

        $display("covered %0d requests: %0d push, %0d read top, %0d pop",
                 sent, sb.n_push, sb.n_top, sb.n_pop);
        $display("drops on full stacks: %0d, empty hits: %0d, results checked: %0d",
                 sb.n_full, sb.n_empty, sb.n_checked);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
